### rtl/ppu_pkg.sv
// Shared constants and types for the partial permutation unrank block.
// No dependencies; the rtl files other than ppu_if use scoped names, the bench imports it.
`default_nettype none

package ppu_pkg;

    // Largest pool the list cells can hold.
    localparam int MAX_POOL = 16;

    // Fixed field widths of the channels and the config register.
    localparam int SEED_W  = 45;
    localparam int COUNT_W = 5;
    localparam int POOL_W  = 5;
    localparam int OUT_W   = 4;

    // Widths derived from the pool depth.
    localparam int IDX_W   = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int CNT_W   = $clog2(MAX_POOL + 1);
    localparam int CMP_W   = (CNT_W > POOL_W) ? CNT_W : POOL_W;
    localparam int STEP_W  = $clog2(SEED_W);

    // Control broadcast to every list cell.
    typedef struct packed {
        logic             load;
        logic             shift;
        logic [IDX_W-1:0] pos;
    } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/ppu_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on nothing but the field widths written out here.
`default_nettype none

interface ppu_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  pick_count;
    logic [44:0] rank_seed;

    modport source (output valid, output pick_count, output rank_seed, input ready);
    modport sink   (input valid, input pick_count, input rank_seed, output ready);
endinterface

interface ppu_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] chosen_index;
    logic       last_pick;
    logic       bad_request;

    modport source (output valid, output chosen_index, output last_pick,
                    output bad_request, input ready);
    modport sink   (input valid, input chosen_index, input last_pick,
                    input bad_request, output ready);
endinterface

`default_nettype wire

### rtl/partial_permutation_unrank.sv
// Top level of the k-permutation unranking block: control sequencer, list cells, divider.
// Depends on ppu_pkg, ppu_if, ppu_cell and ppu_div.
`default_nettype none

// A request item carries a pick count and a rank seed; the block answers with one
// result item per pick, drawn in mixed radix from the pool 0 .. pool_size-1: the
// seed modulo the number of indices still left picks a list position, that index
// is emitted and removed, and the seed is divided by the same number. last_pick
// marks the final result of a selection. A pick count of zero or above the pool
// size (pool_size is clamped to MAX_POOL) gives a single result with bad_request
// and last_pick set and index zero. Each pick waits on the restoring divider,
// which retires one quotient bit per cycle; a bad request skips the divider and
// goes straight to the emit state. One request is worked at a time; the next one is
// taken as soon as the last result sits in the output register. Write pool_size
// only while the block is idle; it resets to 16.
module partial_permutation_unrank (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ppu_req_if.sink                          req,
    ppu_rsp_if.source                        rsp,
    input  wire logic                        cfg_we,
    input  wire logic [ppu_pkg::POOL_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int IDX_EXT_W = ppu_pkg::IDX_W + ppu_pkg::OUT_W;

    logic [1:0]                   state_reg;
    logic [ppu_pkg::POOL_W-1:0]   pool_size_reg;
    logic [ppu_pkg::CNT_W-1:0]    left_reg;
    logic [ppu_pkg::CNT_W-1:0]    picks_reg;

    // Pending result, held until the output register is free.
    logic [ppu_pkg::OUT_W-1:0]    pend_idx_reg;
    logic                         pend_last_reg;
    logic                         pend_bad_reg;

    // Output register.
    logic                         rsp_valid_reg;
    logic [ppu_pkg::OUT_W-1:0]    rsp_idx_reg;
    logic                         rsp_last_reg;
    logic                         rsp_bad_reg;

    logic                         accept;
    logic                         out_free;
    logic [ppu_pkg::CMP_W-1:0]    pool_ext;
    logic [ppu_pkg::CMP_W-1:0]    eff_pool;
    logic [ppu_pkg::CMP_W-1:0]    count_ext;
    logic                         bad_count;

    ppu_pkg::cell_ctl_t           cell_ctl;
    logic [ppu_pkg::IDX_W-1:0]    cell_val [ppu_pkg::MAX_POOL];
    logic [ppu_pkg::IDX_W-1:0]    cell_nbr [ppu_pkg::MAX_POOL];
    logic [ppu_pkg::IDX_W-1:0]    sel_val;
    logic [IDX_EXT_W-1:0]         sel_ext;

    logic                         div_start;
    logic [ppu_pkg::SEED_W-1:0]   div_dividend;
    logic [ppu_pkg::CNT_W-1:0]    div_divisor;
    logic                         div_done;
    logic [ppu_pkg::SEED_W-1:0]   div_quot;
    logic [ppu_pkg::CNT_W-1:0]    div_rem;

    // ------------------------------------------------------------------
    // Handshake and request check
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // Clamp the pool to what the cells can hold.
    assign pool_ext  = ppu_pkg::CMP_W'(pool_size_reg);
    assign eff_pool  = (pool_ext > ppu_pkg::CMP_W'(ppu_pkg::MAX_POOL))
                       ? ppu_pkg::CMP_W'(ppu_pkg::MAX_POOL) : pool_ext;
    assign count_ext = ppu_pkg::CMP_W'(req.pick_count);
    assign bad_count = (count_ext == '0) || (count_ext > eff_pool);

    // ------------------------------------------------------------------
    // List cells: load 0..MAX_POOL-1 on a good request, close the gap
    // at the divider's remainder when a pick completes.
    // ------------------------------------------------------------------
    always_comb
    begin
        cell_ctl.load  = accept && !bad_count;
        cell_ctl.shift = (state_reg == ST_DIV) && div_done;
        cell_ctl.pos   = div_rem[ppu_pkg::IDX_W-1:0];
    end

    for (genvar g = 0; g < ppu_pkg::MAX_POOL; g++)
    begin : g_cell
        if (g == ppu_pkg::MAX_POOL - 1)
        begin : g_tail
            assign cell_nbr[g] = '0;
        end
        else
        begin : g_body
            assign cell_nbr[g] = cell_val[g + 1];
        end

        ppu_cell u_cell (
            .clk      (clk),
            .ctl      (cell_ctl),
            .cell_num (ppu_pkg::IDX_W'(g)),
            .right    (cell_nbr[g]),
            .value    (cell_val[g])
        );
    end

    // Pick the index at the remainder position; mask to the output width.
    assign sel_val = cell_val[cell_ctl.pos];
    assign sel_ext = IDX_EXT_W'(sel_val);

    // ------------------------------------------------------------------
    // Divider: first pick divides the request seed by the pool, later
    // picks divide the previous quotient by what is left.
    // ------------------------------------------------------------------
    assign div_start    = (accept && !bad_count)
                          || ((state_reg == ST_EMIT) && out_free && !pend_last_reg);
    assign div_dividend = (state_reg == ST_IDLE) ? req.rank_seed : div_quot;
    assign div_divisor  = (state_reg == ST_IDLE) ? ppu_pkg::CNT_W'(eff_pool) : left_reg;

    ppu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // Sequencer and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pool_size_reg <= ppu_pkg::POOL_W'(16);
            left_reg      <= '0;
            picks_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pool_size_reg <= cfg_data;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        left_reg  <= ppu_pkg::CNT_W'(eff_pool);
                        picks_reg <= ppu_pkg::CNT_W'(req.pick_count);
                        state_reg <= bad_count ? ST_EMIT : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        left_reg  <= left_reg - 1'b1;
                        picks_reg <= picks_reg - 1'b1;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= pend_last_reg ? ST_IDLE : ST_DIV;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Hold the result until taken; refill from the pending slot.
            if ((state_reg == ST_EMIT) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept && bad_count)
        begin
            pend_idx_reg  <= '0;
            pend_last_reg <= 1'b1;
            pend_bad_reg  <= 1'b1;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            pend_idx_reg  <= sel_ext[ppu_pkg::OUT_W-1:0];
            pend_last_reg <= (picks_reg == ppu_pkg::CNT_W'(1));
            pend_bad_reg  <= 1'b0;
        end

        if ((state_reg == ST_EMIT) && out_free)
        begin
            rsp_idx_reg  <= pend_idx_reg;
            rsp_last_reg <= pend_last_reg;
            rsp_bad_reg  <= pend_bad_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.chosen_index = rsp_idx_reg;
    assign rsp.last_pick    = rsp_last_reg;
    assign rsp.bad_request  = rsp_bad_reg;

`ifndef SYNTHESIS
    // A taken request always leaves idle on the next edge.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // While dividing there is at least one pick due and never more than left.
    a_picks_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((picks_reg != '0) && (picks_reg <= left_reg)))
        else $error("pick counter out of step with list length");

    // The divider only finishes while a pick is being worked.
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside a pick");

    // A rejected request shows as a lone last result with index zero.
    a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_bad_reg) |-> (rsp_last_reg && (rsp_idx_reg == '0)))
        else $error("bad request result malformed");
`endif

endmodule

`default_nettype wire

### rtl/ppu_cell.sv
// One entry of the remaining-index list; takes its right neighbor on removal.
// Depends on ppu_pkg.
`default_nettype none

module ppu_cell (
    input  wire logic                    clk,
    input  wire ppu_pkg::cell_ctl_t      ctl,
    input  wire logic [ppu_pkg::IDX_W-1:0] cell_num,
    input  wire logic [ppu_pkg::IDX_W-1:0] right,
    output      logic [ppu_pkg::IDX_W-1:0] value
);

    logic [ppu_pkg::IDX_W-1:0] value_reg;
    logic [ppu_pkg::IDX_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            value_next = cell_num;
        end
        else if (ctl.shift && (cell_num >= ctl.pos))
        begin
            value_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### rtl/ppu_div.sv
// Restoring divider, one quotient bit per cycle, small divisor.
// Depends on ppu_pkg.
`default_nettype none

module ppu_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ppu_pkg::SEED_W-1:0] dividend,
    input  wire logic [ppu_pkg::CNT_W-1:0]  divisor,
    output      logic                       done,
    output      logic [ppu_pkg::SEED_W-1:0] quotient,
    output      logic [ppu_pkg::CNT_W-1:0]  remainder
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [ppu_pkg::STEP_W-1:0] step_reg;
    logic [ppu_pkg::SEED_W-1:0] dvd_reg;
    logic [ppu_pkg::CNT_W-1:0]  dsr_reg;
    logic [ppu_pkg::CNT_W-1:0]  rem_reg;

    logic [ppu_pkg::CNT_W:0]    rem_sh;
    logic [ppu_pkg::CNT_W:0]    rem_sub;
    logic                       q_bit;
    logic [ppu_pkg::CNT_W-1:0]  rem_next;

    // Bring down the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[ppu_pkg::SEED_W-1]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
        q_bit   = (rem_sh >= {1'b0, dsr_reg});
        rem_next = q_bit ? rem_sub[ppu_pkg::CNT_W-1:0] : rem_sh[ppu_pkg::CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= ppu_pkg::STEP_W'(ppu_pkg::SEED_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ppu_pkg::SEED_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### tb/ppu_scoreboard_pkg.sv
// Scoreboard for the partial permutation unrank block: mixed-radix pick predictor
// and in-order result check. Depends on ppu_pkg for MAX_POOL.
package ppu_scoreboard_pkg;

    import ppu_pkg::*;

    class pick_scoreboard;

        typedef struct packed {
            logic [3:0] chosen_index;
            logic       last_pick;
            logic       bad_request;
        } pick_result_t;

        pick_result_t expected_picks[$];
        logic [4:0]   pool_size;
        int unsigned  mismatches;

        function new();
            pool_size   = 5'd16;
            mismatches  = 0;
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        // Append one expected pick at the tail of the queue.
        function void queue_pick(pick_result_t pick);
            expected_picks.insert(expected_picks.size(), pick);
        endfunction

        // Decode one accepted request into the picks it must produce.
        function void unrank_request(logic [4:0] count, logic [44:0] seed);
            logic [3:0]   pool_list [MAX_POOL];
            logic [44:0]  seed_rest;
            logic [44:0]  pos;
            int unsigned  pool;
            int unsigned  left;
            pick_result_t pick;

            pool = (pool_size > MAX_POOL) ? MAX_POOL : pool_size;
            if (count == 0 || count > pool)
            begin
                pick.chosen_index = 4'd0;
                pick.last_pick    = 1'b1;
                pick.bad_request  = 1'b1;
                queue_pick(pick);
                return;
            end
            for (int i = 0; i < pool; i++)
                pool_list[i] = 4'(i);
            left      = pool;
            seed_rest = seed;
            for (int k = 0; k < count; k++)
            begin
                pos       = seed_rest % 45'(left);
                seed_rest = seed_rest / 45'(left);
                pick.chosen_index = pool_list[pos];
                pick.last_pick    = (k + 1 == count);
                pick.bad_request  = 1'b0;
                queue_pick(pick);
                // drop the chosen index, close the gap
                for (int i = int'(pos); i + 1 < left; i++)
                    pool_list[i] = pool_list[i + 1];
                left--;
            end
        endfunction

        function void check_pick(logic [3:0] chosen_index, logic last_pick,
                                 logic bad_request);
            pick_result_t want;

            if (expected_picks.size() == 0)
            begin
                $display("%0t: unexpected result item index %0d last %0b bad %0b",
                         $time, chosen_index, last_pick, bad_request);
                mismatches++;
                return;
            end
            want = expected_picks[0];
            expected_picks.delete(0);
            if (chosen_index !== want.chosen_index)
            begin
                $display("%0t: chosen_index expected %0d, got %0d",
                         $time, want.chosen_index, chosen_index);
                mismatches++;
            end
            if (last_pick !== want.last_pick)
            begin
                $display("%0t: last_pick expected %0b, got %0b",
                         $time, want.last_pick, last_pick);
                mismatches++;
            end
            if (bad_request !== want.bad_request)
            begin
                $display("%0t: bad_request expected %0b, got %0b",
                         $time, want.bad_request, bad_request);
                mismatches++;
            end
        endfunction

    endclass

endpackage

### tb/tb_partial_permutation_unrank.sv
// Self-checking bench for partial_permutation_unrank: directed corner requests,
// then random request bursts over several pool sizes. Depends on ppu_pkg, the
// ppu_req_if / ppu_rsp_if interfaces and ppu_scoreboard_pkg.
module tb_partial_permutation_unrank;

    import ppu_pkg::*;
    import ppu_scoreboard_pkg::*;

    // Cycles without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT = 20000;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES = 1500;
    // Largest seed that still names a distinct full-pool order (16! - 1).
    localparam logic [44:0] SEED_FULL_ORDER = 45'd20922789887999;
    localparam logic [44:0] SEED_ONES       = {45{1'b1}};

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [POOL_W-1:0] cfg_data;

    ppu_req_if req_ch ();
    ppu_rsp_if rsp_ch ();

    pick_scoreboard sb;

    // Pool size as the bench last wrote it, for shaping random requests.
    logic [4:0] pool_now;
    int         burst_left;
    bit         hold_off_req;
    int         idle_cycles;

    partial_permutation_unrank dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor and watchdog: sample both channels at the rising edge, when the
    // inputs driven at the falling edge are settled and outputs are pre-update.
    always @(posedge clk)
    begin
        if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        begin
            sb.unrank_request(req_ch.pick_count, req_ch.rank_seed);
            idle_cycles <= 0;
        end
        else if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_pick(rsp_ch.chosen_index, rsp_ch.last_pick, rsp_ch.bad_request);

        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: switch between stall modes of random length; honor a long
    // hold-off when the stimulus asks for one.
    initial
    begin : receiver
        int mode;
        int mode_left;

        mode      = 0;
        mode_left = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // hold ready low while the block fills and stalls its input
                hold_off_req = 1'b0;
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0: rsp_ch.ready = 1'b1;                       // no stalls
                1: rsp_ch.ready = $urandom_range(0, 1);       // coin flip
                2: rsp_ch.ready = ($urandom_range(0, 3) == 0); // mostly stalled
                default: rsp_ch.ready = (mode_left % 4) != 0; // fixed rhythm
            endcase
        end
    end

    // Offer one item and hold it until the block takes it. Called at a
    // falling edge; returns at the falling edge after acceptance with valid
    // still high, so a back-to-back item needs no drop.
    task automatic offer_request(input logic [4:0] count, input logic [44:0] seed);
        req_ch.valid      = 1'b1;
        req_ch.pick_count = count;
        req_ch.rank_seed  = seed;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // Burst pacing: advance within a burst, or drop valid for a random gap.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(0, 30)) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Stop sending and wait for every expected result to come back.
    task automatic drain_results();
        req_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Every request yields at least one result, so the block is idle once
    // the queue of expected picks is empty.
    task automatic write_pool_size(input logic [4:0] size);
        drain_results();
        cfg_we   = 1'b1;
        cfg_data = size;
        @(negedge clk);
        cfg_we   = 1'b0;
        sb.pool_size = size;
        pool_now     = size;
    endtask

    function automatic logic [44:0] random_seed();
        logic [63:0] raw;

        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return 45'($urandom_range(0, 1000));
            1: return raw[44:0] >> $urandom_range(0, 44);
            default: return raw[44:0];
        endcase
    endfunction

    // Mostly well-formed counts for the current pool, some tiny ones, some
    // noise across the whole field (mostly rejected).
    function automatic logic [4:0] random_count();
        int pool;
        int r;

        pool = (pool_now > MAX_POOL) ? MAX_POOL : pool_now;
        r    = $urandom_range(0, 19);
        if (r < 14)
            return 5'($urandom_range(1, (pool > 0) ? pool : 1));
        else if (r < 17)
            return 5'($urandom_range(1, 3));
        else
            return 5'($urandom_range(0, 31));
    endfunction

    task automatic run_random_phase(input logic [4:0] size, input int items);
        write_pool_size(size);
        for (int n = 0; n < items; n++)
        begin
            offer_request(random_count(), random_seed());
            pace_sender();
        end
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        req_ch.valid      = 1'b0;
        req_ch.pick_count = '0;
        req_ch.rank_seed  = '0;
        pool_now     = 5'd16;
        burst_left   = 0;
        hold_off_req = 1'b0;
        idle_cycles  = 0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: rejected counts, full-pool extremes, wrap of the first
        // radix, alternating seed bits.
        write_pool_size(5'd16);
        offer_request(5'd0,  45'd0);
        offer_request(5'd17, 45'd5);
        offer_request(5'd31, SEED_ONES);
        offer_request(5'd16, 45'd0);
        offer_request(5'd16, SEED_FULL_ORDER);
        offer_request(5'd16, SEED_ONES);
        offer_request(5'd1,  45'd0);
        offer_request(5'd1,  45'd15);
        offer_request(5'd1,  45'd16);
        offer_request(5'd2,  45'h155555555555);
        offer_request(5'd3,  45'h0AAAAAAAAAAA);
        offer_request(5'd15, random_seed());

        // Single-item pool: only index 0 exists; two picks is a bad count.
        write_pool_size(5'd1);
        offer_request(5'd1, SEED_ONES);
        offer_request(5'd1, 45'd0);
        offer_request(5'd2, 45'd3);

        // Empty pool: every request is rejected.
        write_pool_size(5'd0);
        offer_request(5'd1, 45'd7);
        offer_request(5'd0, 45'd0);

        // Oversized pool clamps to MAX_POOL.
        write_pool_size(5'd31);
        offer_request(5'd16, 45'd12345);
        offer_request(5'd17, SEED_ONES);
        write_pool_size(5'd17);
        offer_request(5'd16, SEED_FULL_ORDER);
        drain_results();

        // Random: a full-pool phase with a long receiver hold-off in the middle.
        run_random_phase(5'd16, 15);
        drain_results();
        hold_off_req = 1'b1;
        // keep offering back to back so the block backs up against the stall
        for (int n = 0; n < 8; n++)
            offer_request(random_count(), random_seed());
        run_random_phase(5'd16, 17);

        run_random_phase(5'd5,  20);
        run_random_phase(5'd1,  10);
        run_random_phase(5'd31, 25);
        run_random_phase(5'd9,  25);
        run_random_phase(5'd0,  8);
        run_random_phase(5'd16, 25);

        // Wait out stragglers, then watch for spurious results.
        drain_results();
        repeat (50) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
